// ----- sv/afrr_pkg.sv -----
`timescale 1ns / 1ps
// afrr_pkg: shared types, constants and the crc-8 step for the frame receiver ring
// no dependencies; used by every module of the block

package afrr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int RING_SLOTS  = 4;

  localparam int SLOT_W    = $clog2(RING_SLOTS);
  localparam int PIDX_W    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PAY_DEPTH = RING_SLOTS * MAX_PAYLOAD;
  localparam int PAY_AW    = $clog2(PAY_DEPTH);

  localparam logic [7:0] PREAMBLE_RESET = 8'h55;
  localparam logic [7:0] CRC_POLY_REFL  = 8'h8C;

  typedef logic [7:0]        byte_t;
  typedef logic [6:0]        len_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PIDX_W-1:0] pidx_t;
  typedef logic [PAY_AW-1:0] pay_addr_t;

  typedef enum logic [0:0] {
    REG_OWN_ADDR = 1'b0,
    REG_PREAMBLE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    FR_IDLE  = 3'd0,
    FR_SRC   = 3'd1,
    FR_DST   = 3'd2,
    FR_LEN   = 3'd3,
    FR_DATA  = 3'd4,
    FR_CHECK = 3'd5
  } frame_phase_t;

  typedef enum logic [1:0] {
    PS_IDLE  = 2'd0,
    PS_EMPTY = 2'd1,
    PS_EMIT  = 2'd2
  } pop_state_t;

  typedef struct packed {
    logic  kind;
    byte_t line_byte;
  } in_word_t;

  typedef struct packed {
    logic  status;
    byte_t source;
    byte_t destination;
    len_t  length;
    byte_t payload_byte;
    logic  last;
  } out_word_t;

  typedef struct packed {
    byte_t source;
    byte_t destination;
    len_t  length;
  } hdr_t;

  typedef struct packed {
    logic frame_start;
    logic take_src;
    logic take_dst;
    logic take_len;
    logic take_data;
    logic commit;
    logic pop_begin;
    logic pop_next;
    logic pop_finish;
    logic emit_empty;
    logic emit_msg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_preamble;
    logic len_too_big;
    logic len_zero;
    logic data_last;
    logic check_ok;
    logic ring_empty;
    logic pop_last;
  } dp_status_t;

  function automatic byte_t crc8_next(byte_t crc, byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/afrr_ctrl.sv -----
`timescale 1ns / 1ps
// afrr_ctrl: deframer phase machine and pop sequencer
// depends on afrr_pkg; drives the datapath through ctrl_cmd_t

module afrr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  kind,
  input  afrr_pkg::dp_status_t  stat,
  output afrr_pkg::ctrl_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);

  afrr_pkg::frame_phase_t phase, phase_next;
  afrr_pkg::pop_state_t   pstate, pstate_next;
  logic line_acc;
  logic pop_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= afrr_pkg::FR_IDLE;
      pstate <= afrr_pkg::PS_IDLE;
    end else begin
      phase  <= phase_next;
      pstate <= pstate_next;
    end
  end

  assign busy     = (pstate != afrr_pkg::PS_IDLE);
  assign line_acc = start && !busy && !kind;
  assign pop_acc  = start && !busy && kind;
  assign done     = cmd.emit_empty || cmd.emit_msg;

  always_comb begin
    cmd         = '0;
    phase_next  = phase;
    pstate_next = pstate;

    // deframer
    if (line_acc) begin
      unique case (phase)
        afrr_pkg::FR_IDLE: begin
          if (stat.is_preamble) begin
            cmd.frame_start = 1'b1;
            phase_next      = afrr_pkg::FR_SRC;
          end
        end
        afrr_pkg::FR_SRC: begin
          cmd.take_src = 1'b1;
          phase_next   = afrr_pkg::FR_DST;
        end
        afrr_pkg::FR_DST: begin
          cmd.take_dst = 1'b1;
          phase_next   = afrr_pkg::FR_LEN;
        end
        afrr_pkg::FR_LEN: begin
          if (stat.len_too_big) begin
            phase_next = afrr_pkg::FR_IDLE;
          end else begin
            cmd.take_len = 1'b1;
            phase_next   = stat.len_zero ? afrr_pkg::FR_CHECK : afrr_pkg::FR_DATA;
          end
        end
        afrr_pkg::FR_DATA: begin
          cmd.take_data = 1'b1;
          if (stat.data_last) begin
            phase_next = afrr_pkg::FR_CHECK;
          end
        end
        afrr_pkg::FR_CHECK: begin
          cmd.commit = stat.check_ok;
          phase_next = afrr_pkg::FR_IDLE;
        end
        default: begin
          phase_next = afrr_pkg::FR_IDLE;
        end
      endcase
    end

    // pop sequencer
    unique case (pstate)
      afrr_pkg::PS_IDLE: begin
        if (pop_acc) begin
          if (stat.ring_empty) begin
            pstate_next = afrr_pkg::PS_EMPTY;
          end else begin
            cmd.pop_begin = 1'b1;
            pstate_next   = afrr_pkg::PS_EMIT;
          end
        end
      end
      afrr_pkg::PS_EMPTY: begin
        cmd.emit_empty = 1'b1;
        pstate_next    = afrr_pkg::PS_IDLE;
      end
      afrr_pkg::PS_EMIT: begin
        cmd.emit_msg = 1'b1;
        if (stat.pop_last) begin
          cmd.pop_finish = 1'b1;
          pstate_next    = afrr_pkg::PS_IDLE;
        end else begin
          cmd.pop_next = 1'b1;
        end
      end
      default: begin
        pstate_next = afrr_pkg::PS_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/afrr_dpath.sv -----
`timescale 1ns / 1ps
// afrr_dpath: config registers, crc accumulator, ring pointers, header store and payload memory
// depends on afrr_pkg; steered by afrr_ctrl

module afrr_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  afrr_pkg::in_word_t    request,
  input  logic                  cfg_we,
  input  afrr_pkg::reg_idx_t    cfg_index,
  input  afrr_pkg::byte_t       cfg_data,
  input  afrr_pkg::ctrl_cmd_t   cmd,
  output afrr_pkg::dp_status_t  stat,
  output afrr_pkg::out_word_t   result
);

  afrr_pkg::byte_t   own_addr;
  afrr_pkg::byte_t   preamble_byte;
  afrr_pkg::byte_t   crc_accum;
  afrr_pkg::len_t    bytes_left;
  afrr_pkg::pidx_t   fill_index;
  afrr_pkg::slot_t   write_slot;
  afrr_pkg::slot_t   read_slot;
  afrr_pkg::byte_t   frm_src;
  afrr_pkg::byte_t   frm_dst;
  afrr_pkg::len_t    frm_len;
  afrr_pkg::hdr_t    slot_headers [afrr_pkg::RING_SLOTS];
  afrr_pkg::byte_t   slot_payloads [afrr_pkg::PAY_DEPTH];
  afrr_pkg::hdr_t    hdr_q;
  afrr_pkg::pidx_t   pop_k;
  afrr_pkg::byte_t   mem_q;
  afrr_pkg::byte_t   b;
  afrr_pkg::slot_t   write_after;
  afrr_pkg::slot_t   read_after;
  afrr_pkg::pidx_t   rd_idx;
  afrr_pkg::pay_addr_t wr_addr;
  afrr_pkg::pay_addr_t rd_addr;

  assign b = request.line_byte;

  function automatic afrr_pkg::slot_t slot_after(afrr_pkg::slot_t s);
    return (s == afrr_pkg::slot_t'(afrr_pkg::RING_SLOTS - 1)) ? '0 : s + afrr_pkg::slot_t'(1);
  endfunction

  function automatic afrr_pkg::pay_addr_t pay_addr(afrr_pkg::slot_t s, afrr_pkg::pidx_t k);
    return afrr_pkg::pay_addr_t'(afrr_pkg::pay_addr_t'(s)
                                 * afrr_pkg::pay_addr_t'(afrr_pkg::MAX_PAYLOAD))
           + afrr_pkg::pay_addr_t'(k);
  endfunction

  assign write_after = slot_after(write_slot);
  assign read_after  = slot_after(read_slot);
  assign rd_idx      = cmd.pop_begin ? '0 : pop_k + afrr_pkg::pidx_t'(1);
  assign wr_addr     = pay_addr(write_slot, fill_index);
  assign rd_addr     = pay_addr(read_slot, rd_idx);

  // status
  assign stat.is_preamble = (b == preamble_byte);
  assign stat.len_too_big = (b > afrr_pkg::byte_t'(afrr_pkg::MAX_PAYLOAD));
  assign stat.len_zero    = (b == '0);
  assign stat.data_last   = (bytes_left == afrr_pkg::len_t'(1));
  assign stat.check_ok    = (b == crc_accum) && (frm_dst == own_addr);
  assign stat.ring_empty  = (read_slot == write_slot);
  assign stat.pop_last    = (hdr_q.length == '0)
                         || (hdr_q.length == afrr_pkg::len_t'(pop_k) + afrr_pkg::len_t'(1));

  // config and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr      <= '0;
      preamble_byte <= afrr_pkg::PREAMBLE_RESET;
      crc_accum     <= '0;
      bytes_left    <= '0;
      fill_index    <= '0;
      write_slot    <= '0;
      read_slot     <= '0;
      pop_k         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          afrr_pkg::REG_OWN_ADDR: own_addr      <= cfg_data;
          afrr_pkg::REG_PREAMBLE: preamble_byte <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.frame_start) begin
        crc_accum  <= afrr_pkg::crc8_next('0, b);
        fill_index <= '0;
        bytes_left <= '0;
        // ring full: drop the oldest message
        if (write_after == read_slot) begin
          read_slot <= read_after;
        end
      end
      if (cmd.take_src || cmd.take_dst || cmd.take_len || cmd.take_data) begin
        crc_accum <= afrr_pkg::crc8_next(crc_accum, b);
      end
      if (cmd.take_len) begin
        bytes_left <= afrr_pkg::len_t'(b);
        fill_index <= '0;
      end
      if (cmd.take_data) begin
        fill_index <= fill_index + afrr_pkg::pidx_t'(1);
        bytes_left <= bytes_left - afrr_pkg::len_t'(1);
      end
      if (cmd.commit) begin
        write_slot <= write_after;
      end
      if (cmd.pop_begin) begin
        pop_k <= '0;
      end else if (cmd.pop_next) begin
        pop_k <= pop_k + afrr_pkg::pidx_t'(1);
      end
      if (cmd.pop_finish) begin
        read_slot <= read_after;
      end
    end
  end

  // frame header fields and header store
  always_ff @(posedge clk) begin
    if (cmd.take_src) begin
      frm_src <= b;
    end
    if (cmd.take_dst) begin
      frm_dst <= b;
    end
    if (cmd.take_len) begin
      frm_len <= afrr_pkg::len_t'(b);
    end
    if (cmd.commit) begin
      slot_headers[write_slot] <= '{source: frm_src, destination: frm_dst, length: frm_len};
    end
    if (cmd.pop_begin) begin
      hdr_q <= slot_headers[read_slot];
    end
  end

  // payload memory
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      slot_payloads[wr_addr] <= b;
    end
    mem_q <= slot_payloads[rd_addr];
  end

  always_comb begin
    result = '0;
    if (cmd.emit_empty) begin
      result.status = 1'b1;
      result.last   = 1'b1;
    end else if (cmd.emit_msg) begin
      result.source       = hdr_q.source;
      result.destination  = hdr_q.destination;
      result.length       = hdr_q.length;
      result.payload_byte = (hdr_q.length == '0) ? '0 : mem_q;
      result.last         = stat.pop_last;
    end
  end

endmodule

// ----- sv/addressed_frame_receiver_ring_core.sv -----
`timescale 1ns / 1ps
// addressed_frame_receiver_ring_core: top level of the addressed frame receiver with message ring
// depends on afrr_pkg, afrr_ctrl and afrr_dpath
//
//   channel   ports                         handshake
//   input     request (kind, line_byte)     taken when start and not busy
//   result    result (status .. last)       done strobe, high with each word
//   config    cfg_we, cfg_index, cfg_data   written when cfg_we is high
//
// a line byte leaves busy low and gives no result
// a pop on an empty ring gives one status word; otherwise it first fetches the header
//   and starts the first payload read, then emits max(n, 1) words for an n-byte message,
//   one word per cycle, paced by the single read port of the payload memory
// reset is synchronous; the ring stores have no clearing pass
// results cannot be stalled: each word is shown for exactly one cycle

module addressed_frame_receiver_ring_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  afrr_pkg::in_word_t   request,
  output logic                 done,
  output afrr_pkg::out_word_t  result,
  input  logic                 cfg_we,
  input  afrr_pkg::reg_idx_t   cfg_index,
  input  afrr_pkg::byte_t      cfg_data
);

  afrr_pkg::ctrl_cmd_t  cmd;
  afrr_pkg::dp_status_t stat;

  afrr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (request.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  afrr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

// ----- sv/afrr_checker.sv -----
`timescale 1ns / 1ps
// afrr_checker: port-level assertions for the frame receiver ring top level
// depends on afrr_pkg; bound to addressed_frame_receiver_ring_core

module afrr_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input afrr_pkg::in_word_t  request,
  input logic                done,
  input afrr_pkg::out_word_t result
);

  // a pop always answers in the next cycle
  a_pop_answers: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.kind |=> done)
    else $error("pop not answered in the next cycle");

  // a line byte never starts a busy period
  a_line_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !request.kind |=> !busy && !done)
    else $error("line byte caused busy or a result");

  // a message streams without gaps until its last word
  a_stream: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done)
    else $error("gap inside a message stream");

  // block is free right after the last word
  a_free_after_last: assert property (@(posedge clk) disable iff (rst)
    done && result.last |=> !busy && !done)
    else $error("still busy after last word");

  // empty status is a single zeroed word
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> result.last && result.source == '0
      && result.destination == '0 && result.length == '0 && result.payload_byte == '0)
    else $error("malformed empty status word");

endmodule

bind addressed_frame_receiver_ring_core afrr_checker u_afrr_checker (.*);
